// File: design/call_stack_tracker_macros.svh
// Assertion macros for the call stack tracker checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef CALL_STACK_TRACKER_MACROS_SVH
`define CALL_STACK_TRACKER_MACROS_SVH

// Implication that must hold in the same cycle as the antecedent.
`define CST_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Implication that must hold in the cycle after the antecedent.
`define CST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/cst_pkg.sv
// Shared types and constants of the call stack tracker.
// Depends on nothing; imported by the tracker, its checker and the testbench.
package cst_pkg;

  localparam int FUNC_ID_W = 16;
  localparam int DEPTH_W   = 7;

  // Instruction decode masks and match values.
  localparam logic [31:0] OPC_JAL_MASK  = 32'h0000_007f;
  localparam logic [31:0] OPC_JAL       = 32'h0000_006f;
  localparam logic [31:0] OPC_JALR_MASK = 32'h0000_707f;
  localparam logic [31:0] OPC_JALR      = 32'h0000_0067;
  localparam logic [31:0] OPC_XRET_MASK = 32'hcfff_ffff;
  localparam logic [31:0] OPC_XRET      = 32'h0020_0073;
  localparam logic [4:0]  REG_ZERO      = 5'd0;
  localparam logic [4:0]  REG_RA        = 5'd1;
  localparam logic [11:0] IMM_ZERO      = 12'd0;

  typedef enum logic [1:0] {
    KIND_REPORT   = 2'd0,
    KIND_UNMAPPED = 2'd1,
    KIND_XRET     = 2'd2
  } kind_e;

  typedef struct packed {
    logic        event_req;
    logic [31:0] pc;
    logic [31:0] opcode;
    logic [63:0] timestamp;
    logic        func_found;
    logic [15:0] func_id;
  } cst_in_t;

  typedef struct packed {
    kind_e       kind;
    logic        last;
    logic [31:0] report_pc;
    logic [63:0] report_time;
    logic [6:0]  depth;
    logic        in_irq;
    logic        stack_empty;
    logic [15:0] top_function;
    logic        top_unmapped;
    logic        overflow;
  } cst_out_t;

  // Context fields of one result.
  typedef struct packed {
    logic [DEPTH_W-1:0]   depth;
    logic                 in_irq;
    logic                 stack_empty;
    logic [FUNC_ID_W-1:0] top_function;
    logic                 top_unmapped;
    logic                 overflow;
  } snap_t;

endpackage

// File: design/cst_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module cst_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/call_stack_tracker.sv
// Shadow call stack tracker: top level, frame update and result queue.
// Depends on cst_pkg and cst_ram.
//
//   channel | signals                       | payload
//   --------+-------------------------------+-----------------------------------
//   input   | in_valid_i / in_ready_o       | cst_in_t: event or retired instr
//   output  | out_valid_o / out_ready_i     | cst_out_t: note or stack report
//
// An accepted item waits in the input register until it is handled, and its
// results are then offered from the result register.
// While the output is not stalled, items that cause at most one result are
// sustained at one item per clock; an item with two or three results holds the
// input side until its last result is being taken, as the result register
// hands out one per cycle.
// Reset clears only control state; the frame RAM needs no clearing pass.
// A stalled output holds its result, and one further item waits in the input
// register meanwhile.
module call_stack_tracker import cst_pkg::*; #(
  parameter int FRAME_DEPTH   = 64,
  parameter int CONTEXT_DEPTH = 8,
  parameter int FUNC_ID_BITS  = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  cst_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cst_out_t out_data_o
);

  // Stored ids never exceed the width of the incoming func_id field.
  localparam int IdW     = (FUNC_ID_BITS < FUNC_ID_W) ? FUNC_ID_BITS : FUNC_ID_W;
  localparam int FrW     = IdW + 1;
  localparam int AddrW   = $clog2(FRAME_DEPTH);
  localparam int CntW    = $clog2(FRAME_DEPTH + 1);
  localparam int CtxIdxW = $clog2(CONTEXT_DEPTH);
  localparam int CtxCntW = $clog2(CONTEXT_DEPTH + 1);

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_CALL = 2'd1;
  localparam logic [1:0] PEND_IRQ  = 2'd2;

  // Input register.
  logic    in_vld_q, in_vld_d;
  cst_in_t in_q;

  // Tracker state. The top frame is cached in top_q; after a pop the new top
  // is fetched from the RAM and arrives as its read data in the next cycle.
  logic [CntW-1:0]    fc_q, fc_d;
  logic [CtxCntW-1:0] cc_q, cc_d;
  logic [1:0]         pend_q, pend_d;
  logic               ovf_q, ovf_d;
  logic [FrW-1:0]     top_q, top_d;
  logic               fetch_q, fetch_d;
  logic [CntW-1:0]    ctx_base_q [CONTEXT_DEPTH];

  // Result register: one pending bit per result slot, in emission order:
  // unmapped-pc note, stack report, spurious xRET note.
  logic [2:0]  res_q, res_d;
  logic [31:0] res_pc_q;
  logic [63:0] res_time_q;
  snap_t       snap0_q, snap1_q;

  logic [FrW-1:0] ram_rdata;
  logic [FrW-1:0] top_w;
  logic [CntW-1:0] base_w;

  // Decode.
  logic [4:0]  rd, rs1;
  logic [11:0] imm;
  logic        is_jal, is_jalr, is_xret, is_ret, is_call;
  logic [FrW-1:0] frame_in;

  // Frame update and pop.
  logic [CntW-1:0]    depth0, depth1, fc1, fc2, base1;
  logic [CtxCntW-1:0] cc1, cc2;
  logic [FrW-1:0]     top1;
  logic               ovf1, report, spurious, pop;
  logic               wr_c, ctx_wr_c;
  logic [AddrW-1:0]   waddr_c;
  logic [1:0]         pend2;
  logic               space_frame, space_ctx;

  // Handshake.
  logic       proc, is_event, upd;
  logic [2:0] sel, rest;
  logic       res_last;
  snap_t      snap0_c, snap1_c, snap_live, snap_out;

  function automatic snap_t make_snap(logic [CntW-1:0] depth, logic irq,
                                      logic [FrW-1:0] top, logic ovf);
    snap_t s;
    s.depth        = DEPTH_W'(depth);
    s.in_irq       = irq;
    s.stack_empty  = (depth == '0);
    s.top_unmapped = (depth != '0) && top[FrW-1];
    s.top_function = ((depth != '0) && !top[FrW-1]) ? FUNC_ID_W'(top[IdW-1:0]) : '0;
    s.overflow     = ovf;
    return s;
  endfunction

  assign top_w  = fetch_q ? ram_rdata : top_q;
  assign base_w = (cc_q == CtxCntW'(1)) ? '0 : ctx_base_q[CtxIdxW'(cc_q - CtxCntW'(1))];

  assign rd      = in_q.opcode[11:7];
  assign rs1     = in_q.opcode[19:15];
  assign imm     = in_q.opcode[31:20];
  assign is_jal  = (in_q.opcode & OPC_JAL_MASK) == OPC_JAL;
  assign is_jalr = (in_q.opcode & OPC_JALR_MASK) == OPC_JALR;
  assign is_xret = (in_q.opcode & OPC_XRET_MASK) == OPC_XRET;
  assign is_ret  = is_jalr && (rs1 == REG_RA) && (rd == REG_ZERO) && (imm == IMM_ZERO);
  assign is_call = (is_jal || is_jalr) && (rd == REG_RA);

  assign frame_in = in_q.func_found ? {1'b0, in_q.func_id[IdW-1:0]} : {1'b1, IdW'(0)};

  assign depth0      = fc_q - base_w;
  assign space_frame = fc_q < CntW'(FRAME_DEPTH);
  assign space_ctx   = cc_q < CtxCntW'(CONTEXT_DEPTH);

  // Frame update: a pending interrupt opens a context, a pending call or an empty context
  // pushes, otherwise a change of function relabels the top; when full, overflow is set.
  always_comb begin
    fc1      = fc_q;
    cc1      = cc_q;
    base1    = base_w;
    top1     = top_w;
    ovf1     = ovf_q;
    report   = 1'b0;
    wr_c     = 1'b0;
    ctx_wr_c = 1'b0;
    waddr_c  = fc_q[AddrW-1:0];
    unique case (pend_q)
      PEND_IRQ: begin
        report = 1'b1;
        if (space_ctx && space_frame) begin
          ctx_wr_c = 1'b1;
          cc1      = cc_q + CtxCntW'(1);
          base1    = fc_q;
          wr_c     = 1'b1;
          fc1      = fc_q + CntW'(1);
          top1     = frame_in;
        end else begin
          ovf1 = 1'b1;
        end
      end
      PEND_CALL: begin
        report = 1'b1;
        if (space_frame) begin
          wr_c = 1'b1;
          fc1  = fc_q + CntW'(1);
          top1 = frame_in;
        end else begin
          ovf1 = 1'b1;
        end
      end
      default: begin
        if (depth0 == '0) begin
          report = 1'b1;
          if (space_frame) begin
            wr_c = 1'b1;
            fc1  = fc_q + CntW'(1);
            top1 = frame_in;
          end else begin
            ovf1 = 1'b1;
          end
        end else if (top_w != frame_in) begin
          report  = 1'b1;
          wr_c    = 1'b1;
          waddr_c = AddrW'(fc_q - CntW'(1));
          top1    = frame_in;
        end
      end
    endcase
  end

  assign depth1 = fc1 - base1;

  // Pop stage, with xRET ahead of return ahead of call.
  always_comb begin
    fc2      = fc1;
    cc2      = cc1;
    pop      = 1'b0;
    spurious = 1'b0;
    pend2    = PEND_NONE;
    priority if (is_xret) begin
      if (cc1 > CtxCntW'(1)) begin
        fc2 = base1;
        cc2 = cc1 - CtxCntW'(1);
        pop = 1'b1;
      end else begin
        spurious = 1'b1;
        if (depth1 != '0) begin
          fc2 = fc1 - CntW'(1);
          pop = 1'b1;
        end
      end
    end else if (is_ret) begin
      if (depth1 != '0) begin
        fc2 = fc1 - CntW'(1);
        pop = 1'b1;
      end
    end else if (is_call) begin
      pend2 = PEND_CALL;
    end
  end

  // Result slot selection: the lowest pending slot goes out first.
  assign sel[0]   = res_q[0];
  assign sel[1]   = !res_q[0] && res_q[1];
  assign sel[2]   = !res_q[0] && !res_q[1] && res_q[2];
  assign rest     = res_q & ~sel;
  assign res_last = (rest == '0);

  assign is_event   = in_q.event_req;
  assign proc       = in_vld_q && ((res_q == '0) || (out_ready_i && res_last));
  assign upd        = proc && !is_event;
  assign in_ready_o = !in_vld_q || proc;
  assign in_vld_d   = in_ready_o ? in_valid_i : in_vld_q;

  assign snap0_c   = make_snap(depth0, cc_q > CtxCntW'(1), top_w, ovf_q);
  assign snap1_c   = make_snap(depth1, cc1 > CtxCntW'(1), top1, ovf1);
  // The xRET note shows the state left by its own item, which stays put
  // until the note has gone out.
  assign snap_live = make_snap(depth0, cc_q > CtxCntW'(1), top_w, ovf_q);

  always_comb begin
    fc_d    = fc_q;
    cc_d    = cc_q;
    pend_d  = pend_q;
    ovf_d   = ovf_q;
    top_d   = top_w;
    fetch_d = 1'b0;
    res_d   = res_q;
    if (out_valid_o && out_ready_i) begin
      res_d = rest;
    end
    if (proc) begin
      if (is_event) begin
        pend_d = PEND_IRQ;
      end else begin
        fc_d    = fc2;
        cc_d    = cc2;
        pend_d  = pend2;
        ovf_d   = ovf1;
        top_d   = top1;
        fetch_d = pop;
        res_d   = {spurious, report, !in_q.func_found};
      end
    end
  end

  cst_ram #(
    .WIDTH (FrW),
    .DEPTH (FRAME_DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (upd && wr_c),
    .waddr_i (waddr_c),
    .wdata_i (frame_in),
    .re_i    (upd && pop && (fc2 != '0)),
    .raddr_i (AddrW'(fc2 - CntW'(1))),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      fc_q     <= '0;
      cc_q     <= CtxCntW'(1);
      pend_q   <= PEND_NONE;
      ovf_q    <= 1'b0;
      fetch_q  <= 1'b0;
      res_q    <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      fc_q     <= fc_d;
      cc_q     <= cc_d;
      pend_q   <= pend_d;
      ovf_q    <= ovf_d;
      fetch_q  <= fetch_d;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      in_q <= in_data_i;
    end
    top_q <= top_d;
    if (upd && ctx_wr_c) begin
      ctx_base_q[CtxIdxW'(cc_q)] <= fc_q;
    end
    if (upd) begin
      res_pc_q   <= in_q.pc;
      res_time_q <= in_q.timestamp;
      snap0_q    <= snap0_c;
      snap1_q    <= snap1_c;
    end
  end

  assign out_valid_o = (res_q != '0);
  assign snap_out    = sel[0] ? snap0_q : (sel[1] ? snap1_q : snap_live);

  always_comb begin
    out_data_o.kind         = sel[0] ? KIND_UNMAPPED : (sel[1] ? KIND_REPORT : KIND_XRET);
    out_data_o.last         = res_last;
    out_data_o.report_pc    = res_pc_q;
    out_data_o.report_time  = res_time_q;
    out_data_o.depth        = snap_out.depth;
    out_data_o.in_irq       = snap_out.in_irq;
    out_data_o.stack_empty  = snap_out.stack_empty;
    out_data_o.top_function = snap_out.top_function;
    out_data_o.top_unmapped = snap_out.top_unmapped;
    out_data_o.overflow     = snap_out.overflow;
  end

endmodule

// File: design/cst_checker.sv
// Port-level checker for the call stack tracker, bound to its top level.
// Depends on cst_pkg and call_stack_tracker_macros.svh.
`include "call_stack_tracker_macros.svh"

module cst_checker import cst_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input cst_out_t out_data_i
);

  `CST_ASSERT_NOW(a_empty_means_no_depth, clk_i, rst_ni, out_valid_i, out_data_i.stack_empty == (out_data_i.depth == '0), "stack_empty disagrees with depth")

  `CST_ASSERT_NOW(a_empty_has_no_top, clk_i, rst_ni, out_valid_i && out_data_i.stack_empty, (out_data_i.top_function == '0) && !out_data_i.top_unmapped, "empty stack shows a top frame")

  `CST_ASSERT_NOW(a_xret_note_last_main, clk_i, rst_ni, out_valid_i && (out_data_i.kind == KIND_XRET), out_data_i.last && !out_data_i.in_irq, "xRET note not last or not in main context")

  `CST_ASSERT_NEXT(a_stalled_result_held, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "stalled item changed")

endmodule

bind call_stack_tracker cst_checker u_cst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

// File: sim/tb_call_stack_tracker.sv
// Self-checking testbench for the call stack tracker: drives retirement traces and
// interrupt events, predicts every result and compares it field by field.
// Depends on cst_pkg and the call_stack_tracker RTL.
`timescale 1ns / 1ps

module tb_call_stack_tracker;
  import cst_pkg::*;

  localparam int FRAME_DEPTH   = 64;
  localparam int CONTEXT_DEPTH = 8;
  localparam int FUNC_ID_BITS  = 16;
  localparam int LIMIT_CYCLES  = 200_000;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_REPORTED  = 10;

  // Instruction words used by the directed traces.
  localparam logic [31:0] OP_NOP       = 32'h0000_0013;
  localparam logic [31:0] OP_ALL_ONES  = 32'hffff_ffff;
  localparam logic [31:0] OP_CALL_JAL  = 32'h0000_00ef;  // jal  ra, 0
  localparam logic [31:0] OP_CALL_JALR = 32'h0000_80e7;  // jalr ra, 0(ra)
  localparam logic [31:0] OP_JALR_A5   = 32'h0007_80e7;  // jalr ra, 0(a5)
  localparam logic [31:0] OP_RET       = 32'h0000_8067;  // jalr x0, 0(ra)
  localparam logic [31:0] OP_MRET      = 32'h3020_0073;
  localparam logic [31:0] OP_SRET      = 32'h1020_0073;
  localparam logic [31:0] OP_URET      = 32'h0020_0073;
  localparam logic [6:0]  OPC_ADDI     = 7'h13;
  localparam logic [16:0] UNMAPPED     = 17'h1_0000;

  // What the next retired instruction has been armed to do.
  typedef enum logic [1:0] {
    ARM_NONE = 2'd0,
    ARM_CALL = 2'd1,
    ARM_IRQ  = 2'd2
  } arm_e;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  cst_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  cst_out_t out_data;

  call_stack_tracker #(
    .FRAME_DEPTH  (FRAME_DEPTH),
    .CONTEXT_DEPTH(CONTEXT_DEPTH),
    .FUNC_ID_BITS (FUNC_ID_BITS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the tracker state. Bit 16 of a frame marks an unmapped
  // location; the low bits hold the function id.
  logic [16:0] frames [FRAME_DEPTH];
  int unsigned ctx_base [CONTEXT_DEPTH];
  int unsigned n_frames;
  int unsigned n_ctx;
  arm_e        armed;
  logic        sticky_ovf;

  cst_out_t    expected_reports [$];
  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic int unsigned active_depth();
    return n_frames - ctx_base[n_ctx - 1];
  endfunction

  // The context fields of a result reflect the shadow state at the moment the
  // result is formed, so the caller decides when to take the snapshot.
  function automatic cst_out_t stack_snapshot(kind_e kind, cst_in_t item);
    cst_out_t    s;
    int unsigned d;
    logic [16:0] top;
    d   = active_depth();
    top = (d > 0) ? frames[n_frames - 1] : '0;
    s.kind         = kind;
    s.last         = 1'b0;
    s.report_pc    = item.pc;
    s.report_time  = item.timestamp;
    s.depth        = DEPTH_W'(d);
    s.in_irq       = (n_ctx > 1);
    s.stack_empty  = (d == 0);
    s.top_function = top[16] ? '0 : top[15:0];
    s.top_unmapped = top[16];
    s.overflow     = sticky_ovf;
    return s;
  endfunction

  function automatic void push_frame(logic [16:0] frame);
    if (n_frames < FRAME_DEPTH) begin
      frames[n_frames] = frame;
      n_frames++;
    end else begin
      sticky_ovf = 1'b1;
    end
  endfunction

  function automatic void clear_shadow_stack();
    n_frames   = 0;
    n_ctx      = 1;
    armed      = ARM_NONE;
    sticky_ovf = 1'b0;
    foreach (ctx_base[i]) ctx_base[i] = 0;
  endfunction

  // Applies one accepted item to the shadow state and queues its results in
  // order: unmapped-pc note, stack report, spurious-xRET note.
  function automatic void update_shadow_stack(cst_in_t item);
    cst_out_t    res [3];
    int          n;
    logic [16:0] frame;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [11:0] imm;
    logic        is_jal;
    logic        is_jalr;
    logic        is_xret;
    n       = 0;
    frame   = item.func_found ? {1'b0, item.func_id} : UNMAPPED;
    rd      = item.opcode[11:7];
    rs1     = item.opcode[19:15];
    imm     = item.opcode[31:20];
    is_jal  = (item.opcode & OPC_JAL_MASK) == OPC_JAL;
    is_jalr = (item.opcode & OPC_JALR_MASK) == OPC_JALR;
    is_xret = (item.opcode & OPC_XRET_MASK) == OPC_XRET;

    if (item.event_req) begin
      armed = ARM_IRQ;
      return;
    end

    if (!item.func_found) begin
      res[n] = stack_snapshot(KIND_UNMAPPED, item);
      n++;
    end

    if (armed == ARM_IRQ) begin
      if (n_ctx < CONTEXT_DEPTH && n_frames < FRAME_DEPTH) begin
        ctx_base[n_ctx] = n_frames;
        n_ctx++;
        push_frame(frame);
      end else begin
        sticky_ovf = 1'b1;
      end
      res[n] = stack_snapshot(KIND_REPORT, item);
      n++;
    end else if (armed == ARM_CALL || active_depth() == 0) begin
      push_frame(frame);
      res[n] = stack_snapshot(KIND_REPORT, item);
      n++;
    end else if (frames[n_frames - 1] != frame) begin
      frames[n_frames - 1] = frame;
      res[n] = stack_snapshot(KIND_REPORT, item);
      n++;
    end
    armed = ARM_NONE;

    if (is_xret) begin
      if (n_ctx > 1) begin
        n_frames = ctx_base[n_ctx - 1];
        n_ctx--;
      end else begin
        if (active_depth() > 0) n_frames--;
        res[n] = stack_snapshot(KIND_XRET, item);
        n++;
      end
    end else if (is_jalr && rs1 == REG_RA && rd == REG_ZERO && imm == IMM_ZERO) begin
      if (active_depth() > 0) n_frames--;
    end else if ((is_jal || is_jalr) && rd == REG_RA) begin
      armed = ARM_CALL;
    end

    if (n > 0) res[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_reports = {expected_reports, res[i]};
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every accepted result is matched against the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    cst_out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
          $display("[%0t] unexpected result: kind %0d pc %h", $realtime,
                   out_data.kind, out_data.report_pc);
      end else begin
        exp_r = expected_reports.pop_front();
        if (out_data.kind !== exp_r.kind || out_data.last !== exp_r.last ||
            out_data.report_pc !== exp_r.report_pc ||
            out_data.report_time !== exp_r.report_time ||
            out_data.depth !== exp_r.depth || out_data.in_irq !== exp_r.in_irq ||
            out_data.stack_empty !== exp_r.stack_empty ||
            out_data.top_function !== exp_r.top_function ||
            out_data.top_unmapped !== exp_r.top_unmapped ||
            out_data.overflow !== exp_r.overflow) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTED) begin
            $display("[%0t] mismatch, expected: kind %0d last %b pc %h time %h depth %0d",
                     $realtime, exp_r.kind, exp_r.last, exp_r.report_pc,
                     exp_r.report_time, exp_r.depth);
            $display("  irq %b empty %b top %h unmapped %b ovf %b", exp_r.in_irq,
                     exp_r.stack_empty, exp_r.top_function, exp_r.top_unmapped,
                     exp_r.overflow);
            $display("  actual: kind %0d last %b pc %h time %h depth %0d",
                     out_data.kind, out_data.last, out_data.report_pc,
                     out_data.report_time, out_data.depth);
            $display("  irq %b empty %b top %h unmapped %b ovf %b", out_data.in_irq,
                     out_data.stack_empty, out_data.top_function,
                     out_data.top_unmapped, out_data.overflow);
          end
        end
      end
    end
  end

  // The receiver stalls at random; its ready changes only at falling edges.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_reports.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving. Each task is entered at a falling edge and returns at one, so
  // the valid line receives one assignment per time step at most.
  // ---------------------------------------------------------------------------

  task automatic send_item(input cst_in_t item);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    update_shadow_stack(item);
    items_sent++;
    @(negedge clk);
  endtask

  // Holds the sender off until every predicted result has been taken.
  task automatic wait_for_reports();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_reports.size() != 0);
  endtask

  function automatic logic [63:0] random_time();
    return {$urandom, $urandom};
  endfunction

  function automatic cst_in_t instr_in(logic [31:0] op, logic found, logic [15:0] fid);
    cst_in_t it;
    it.event_req  = 1'b0;
    it.pc         = $urandom;
    it.opcode     = op;
    it.timestamp  = random_time();
    it.func_found = found;
    it.func_id    = fid;
    return it;
  endfunction

  // An instruction retired in whatever function currently sits on top.
  function automatic cst_in_t instr_here(logic [31:0] op);
    logic [16:0] top;
    if (active_depth() == 0) return instr_in(op, 1'b1, 16'($urandom_range(7)));
    top = frames[n_frames - 1];
    return instr_in(op, !top[16], top[16] ? 16'($urandom) : top[15:0]);
  endfunction

  // An interrupt event; the remaining fields are ignored and so carry noise.
  function automatic cst_in_t irq_item();
    cst_in_t it;
    it = instr_in($urandom, 1'($urandom), 16'($urandom));
    it.event_req = 1'b1;
    return it;
  endfunction

  function automatic logic [15:0] pick_fid();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($urandom_range(7));
  endfunction

  function automatic logic [31:0] plain_op();
    logic [31:0] r;
    r = $urandom;
    r[6:0] = OPC_ADDI;
    return r;
  endfunction

  function automatic logic [31:0] call_op();
    logic [31:0] r;
    r = $urandom;
    if (r[0]) begin
      r[6:0] = OPC_JAL[6:0];
    end else begin
      r[6:0]   = OPC_JALR[6:0];
      r[14:12] = OPC_JALR[14:12];
    end
    r[11:7] = REG_RA;
    return r;
  endfunction

  // The privilege bits of MRET, SRET and URET lie outside the decode mask.
  function automatic logic [31:0] xret_op();
    logic [31:0] r;
    r = OPC_XRET;
    r[29:28] = 2'($urandom_range(3));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-written trace through every decode path and special case.
  task automatic test_directed();
    cst_in_t it;
    // First instruction lands on an empty stack at the lowest pc.
    it = instr_in(OP_NOP, 1'b1, 16'h0000);
    it.pc = '0;
    it.timestamp = '0;
    send_item(it);
    // Same function again: nothing reported.
    it = instr_in(OP_NOP, 1'b1, 16'h0000);
    it.pc = '1;
    send_item(it);
    // Landing in another function relabels the top frame.
    it = instr_in(OP_NOP, 1'b1, 16'hffff);
    it.timestamp = '1;
    send_item(it);
    send_item(instr_in(OP_CALL_JAL, 1'b1, 16'hffff));
    send_item(instr_in(OP_NOP, 1'b1, 16'h0001));
    // An interrupt replaces the call armed by the jalr.
    send_item(instr_in(OP_JALR_A5, 1'b1, 16'h0001));
    it = irq_item();
    it.pc = '1;
    it.opcode = OP_ALL_ONES;
    it.timestamp = '1;
    it.func_found = 1'b1;
    it.func_id = '1;
    send_item(it);
    send_item(instr_in(OP_NOP, 1'b1, 16'h0002));
    // Two events in a row arm one context, opened by an unmapped handler.
    send_item(irq_item());
    send_item(irq_item());
    send_item(instr_in(OP_NOP, 1'b0, 16'h1234));
    // Unmapped frames match each other, so the MRET only drops the context.
    send_item(instr_in(OP_MRET, 1'b0, 16'hffff));
    send_item(instr_in(OP_MRET, 1'b1, 16'h0002));
    send_item(instr_in(OP_RET, 1'b1, 16'h0001));
    send_item(instr_in(OP_NOP, 1'b1, 16'hffff));
    // xRET in the main context is spurious and pops a frame.
    send_item(instr_in(OP_SRET, 1'b1, 16'hffff));
    // Unmapped URET on an empty stack: note, push, spurious note.
    send_item(instr_in(OP_URET, 1'b0, 16'h0000));
    wait_for_reports();
    // Return on a one-frame stack empties it again.
    send_item(instr_in(OP_RET, 1'b1, 16'h0003));
    send_item(instr_in(OP_ALL_ONES, 1'b1, 16'h0005));
    // jalr ra, 0(ra) writes ra, so it is a call and not a return.
    send_item(instr_in(OP_CALL_JALR, 1'b1, 16'h0005));
    send_item(instr_in(OP_NOP, 1'b1, 16'h0005));
  endtask

  // Mostly well-formed call, return and interrupt sequences with random
  // content, kept clear of both store limits; the rest is noise.
  task automatic test_random_traces(input int unsigned count);
    int unsigned start;
    int unsigned pick;
    start = items_sent;
    while (items_sent - start < count) begin
      pick = $urandom_range(99);
      if (pick < 25 && n_frames < 40) begin
        send_item(instr_here(call_op()));
        send_item(instr_in(plain_op(), 1'b1, pick_fid()));
      end else if (pick < 45) begin
        send_item(instr_here(OP_RET));
        send_item(instr_here(plain_op()));
      end else if (pick < 55 && n_ctx < CONTEXT_DEPTH - 2 && n_frames < 60) begin
        send_item(irq_item());
        send_item(instr_in(plain_op(), $urandom_range(9) != 0, pick_fid()));
      end else if (pick < 65) begin
        if (n_ctx > 1 || $urandom_range(3) == 0) send_item(instr_here(xret_op()));
        else send_item(instr_here(plain_op()));
      end else if (pick < 75) begin
        send_item(instr_in(plain_op(), 1'b1, pick_fid()));
      end else if (pick < 85) begin
        send_item(instr_in(plain_op(), 1'b0, 16'($urandom)));
      end else begin
        send_item(instr_in($urandom, 1'($urandom), 16'($urandom)));
      end
    end
  endtask

  // Nests interrupts until the context store is full, pushes one more (which
  // is dropped and sets the overflow flag), then unwinds every context.
  task automatic test_context_overflow();
    while (n_ctx < CONTEXT_DEPTH && n_frames < FRAME_DEPTH - 1) begin
      send_item(irq_item());
      send_item(instr_in(plain_op(), 1'b1, pick_fid()));
    end
    send_item(irq_item());
    send_item(instr_in(plain_op(), 1'b1, pick_fid()));
    while (n_ctx > 1) send_item(instr_here(xret_op()));
  endtask

  // A chain of calls fills the frame store; further pushes and an interrupt
  // context are dropped, and the stack is then partly unwound.
  task automatic test_frame_overflow();
    while (n_frames < FRAME_DEPTH) send_item(instr_in(call_op(), 1'b1, pick_fid()));
    repeat (3) send_item(instr_in(call_op(), 1'b1, pick_fid()));
    send_item(irq_item());
    send_item(instr_in(plain_op(), 1'b1, pick_fid()));
    repeat (4) begin
      send_item(instr_here(OP_RET));
      send_item(instr_here(plain_op()));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  initial begin
    clear_shadow_stack();
    mismatch_count    = 0;
    items_sent        = 0;
    cycle_count       = 0;
    sender_idle_pct   = 38;
    receiver_idle_pct = 47;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_traces(10);

    sender_idle_pct   = 47;
    receiver_idle_pct = 38;
    test_random_traces(10);
    test_context_overflow();

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    test_frame_overflow();

    // Let the last results drain, then give the block time to show anything
    // it should not have produced.
    wait_for_reports();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/cst_pkg.sv
design/cst_ram.sv
design/call_stack_tracker.sv
design/cst_checker.sv
sim/tb_call_stack_tracker.sv
